[rtl/rrtr_pkg.sv]
package rrtr_pkg;

  localparam int NUM_TASKS = 64;
  localparam int TASK_W    = 6;
  localparam int STEP_W    = $clog2(NUM_TASKS);

  typedef logic [TASK_W-1:0] task_t;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  typedef struct packed {
    op_t   opcode;
    task_t task_id;
  } req_t;

  typedef struct packed {
    logic  not_found;
    logic  ring_empty;
    task_t current_task;
  } rsp_t;

endpackage

[rtl/rrtr_link_ram.sv]
module rrtr_link_ram (
  input  logic            clk,
  input  logic            we,
  input  rrtr_pkg::task_t waddr,
  input  rrtr_pkg::task_t wdata,
  input  rrtr_pkg::task_t raddr,
  output rrtr_pkg::task_t rdata
);

  rrtr_pkg::task_t mem [rrtr_pkg::NUM_TASKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/rrtr_ctrl.sv]
module rrtr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rrtr_pkg::req_t  req,
  input  logic            rsp_taken,
  output logic            idle,
  output logic            done,
  output rrtr_pkg::rsp_t  rsp,
  output logic            we,
  output rrtr_pkg::task_t waddr,
  output rrtr_pkg::task_t wdata,
  output rrtr_pkg::task_t raddr,
  input  rrtr_pkg::task_t rdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD_LINK = 7'b0000010,
    S_ADD_TAIL = 7'b0000100,
    S_WALK     = 7'b0001000,
    S_UNLINK   = 7'b0010000,
    S_ADV      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t                      state, state_next;
  rrtr_pkg::task_t             tail, tail_next;
  logic                        empty, empty_next;
  logic                        nf, nf_next;
  rrtr_pkg::task_t             prev, prev_next;
  logic [rrtr_pkg::STEP_W-1:0] steps, steps_next;
  rrtr_pkg::task_t             tid, tid_next;

  always_comb begin
    state_next = state;
    tail_next  = tail;
    empty_next = empty;
    nf_next    = nf;
    prev_next  = prev;
    steps_next = steps;
    tid_next   = tid;
    we         = 1'b0;
    waddr      = tid;
    wdata      = tid;
    raddr      = tail;
    case (state)
      S_IDLE: begin
        if (start) begin
          tid_next   = req.task_id;
          nf_next    = 1'b0;
          state_next = S_DONE;
          case (req.opcode)
            rrtr_pkg::OP_CLEAR: begin
              empty_next = 1'b1;
              tail_next  = '0;
            end
            rrtr_pkg::OP_ADD: begin
              if (empty) begin
                we         = 1'b1;
                waddr      = req.task_id;
                wdata      = req.task_id;
                tail_next  = req.task_id;
                empty_next = 1'b0;
              end else begin
                state_next = S_ADD_LINK;
              end
            end
            rrtr_pkg::OP_REMOVE: begin
              if (empty) begin
                nf_next = 1'b1;
              end else begin
                prev_next  = tail;
                steps_next = '0;
                state_next = S_WALK;
              end
            end
            rrtr_pkg::OP_ADVANCE: begin
              if (!empty) begin
                state_next = S_ADV;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_ADD_LINK: begin
        we         = 1'b1;
        waddr      = tid;
        wdata      = rdata;
        state_next = S_ADD_TAIL;
      end
      S_ADD_TAIL: begin
        we         = 1'b1;
        waddr      = tail;
        wdata      = tid;
        tail_next  = tid;
        state_next = S_DONE;
      end
      S_WALK: begin
        raddr = rdata;
        if (rdata == tid) begin
          if (prev == tid) begin
            empty_next = 1'b1;
            tail_next  = '0;
            state_next = S_DONE;
          end else begin
            raddr      = tid;
            state_next = S_UNLINK;
          end
        end else if (steps == rrtr_pkg::STEP_W'(rrtr_pkg::NUM_TASKS - 1)) begin
          nf_next    = 1'b1;
          state_next = S_DONE;
        end else begin
          prev_next  = rdata;
          steps_next = steps + rrtr_pkg::STEP_W'(1);
        end
      end
      S_UNLINK: begin
        we    = 1'b1;
        waddr = prev;
        wdata = rdata;
        if (tid == tail) begin
          tail_next = prev;
        end
        state_next = S_DONE;
      end
      S_ADV: begin
        tail_next  = rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail  <= '0;
      empty <= 1'b1;
      nf    <= 1'b0;
    end else begin
      state <= state_next;
      tail  <= tail_next;
      empty <= empty_next;
      nf    <= nf_next;
    end
  end

  always_ff @(posedge clk) begin
    prev  <= prev_next;
    steps <= steps_next;
    tid   <= tid_next;
  end

  assign idle             = (state == S_IDLE);
  assign done             = (state == S_DONE);
  assign rsp.current_task = empty ? '0 : tail;
  assign rsp.ring_empty   = empty;
  assign rsp.not_found    = nf;

endmodule

[rtl/round_robin_task_ring.sv]
// Channel  Direction  Beat contents (tdata, lowest bit first)
// s_axis   in         opcode[1:0], task_id[7:2]
// m_axis   out        current_task[5:0], ring_empty[6], not_found[7]
//
// Clear, an add to an empty ring, and an advance or a remove on an empty ring go straight to
// done. An add writes the new task's link and then the old tail's link, an advance moves the
// tail on; a remove walks links through the next-pointer read port, then unlinks.
// Reset empties the ring; the link memory is never cleared.
// A new beat is taken while a result waits on m_axis; the next result holds
// in the sequencer until the output register is free.
module round_robin_task_ring (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // opcode, task_id
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // current_task, ring_empty, not_found
);

  logic            idle;
  logic            done;
  logic            rsp_taken;
  rrtr_pkg::req_t  req;
  rrtr_pkg::rsp_t  rsp;
  rrtr_pkg::rsp_t  out_reg;
  logic            we;
  rrtr_pkg::task_t waddr;
  rrtr_pkg::task_t wdata;
  rrtr_pkg::task_t raddr;
  rrtr_pkg::task_t rdata;

  assign req.opcode  = rrtr_pkg::op_t'(s_axis_tdata[1:0]);
  assign req.task_id = s_axis_tdata[7:2];

  assign s_axis_tready = idle;
  assign rsp_taken     = done && (!m_axis_tvalid || m_axis_tready);

  rrtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && s_axis_tready),
    .req       (req),
    .rsp_taken (rsp_taken),
    .idle      (idle),
    .done      (done),
    .rsp       (rsp),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  rrtr_link_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rsp_taken) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_taken) begin
      out_reg <= rsp;
    end
  end

  assign m_axis_tdata = {out_reg.not_found, out_reg.ring_empty, out_reg.current_task};

  a_ready_not_done: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !done)
    else $error("sequencer idle and done at once");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    done && !rsp_taken |=> done)
    else $error("finished result dropped before it was taken");

  a_empty_task_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:0] == 6'd0)
    else $error("empty ring reports a task");

endmodule

[tb/rrtr_checker.sv]
module rrtr_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // opcode, task_id
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // current_task, ring_empty, not_found
  output int         pending,
  output int         errors,
  output int         checked,
  output int         misses
);

  rrtr_pkg::task_t link_mem [rrtr_pkg::NUM_TASKS];
  rrtr_pkg::task_t tail;
  logic            empty;
  rrtr_pkg::rsp_t  expected_rsp [$];
  int              mismatch_cnt;
  int              checked_cnt;
  int              miss_cnt;

  // Only entries written by an add are ever read, so the table needs no clearing.
  function automatic rrtr_pkg::rsp_t ring_apply(rrtr_pkg::op_t op, rrtr_pkg::task_t id);
    rrtr_pkg::rsp_t  r;
    rrtr_pkg::task_t p;
    logic            hit;
    int              step;
    r   = '0;
    hit = 1'b0;
    p   = tail;
    case (op)
      rrtr_pkg::OP_CLEAR: begin
        empty = 1'b1;
        tail  = '0;
      end
      rrtr_pkg::OP_ADD: begin
        if (empty) begin
          link_mem[id] = id;
        end else begin
          link_mem[id]   = link_mem[tail];
          link_mem[tail] = id;
        end
        tail  = id;
        empty = 1'b0;
      end
      rrtr_pkg::OP_REMOVE: begin
        if (!empty) begin
          for (step = 0; step < rrtr_pkg::NUM_TASKS && !hit; step++) begin
            if (link_mem[p] == id) begin
              hit = 1'b1;
            end else begin
              p = link_mem[p];
            end
          end
        end
        r.not_found = !hit;
        if (hit) begin
          if (p == id) begin
            empty = 1'b1;
            tail  = '0;
          end else begin
            link_mem[p] = link_mem[id];
            if (tail == id) begin
              tail = p;
            end
          end
        end
      end
      default: begin
        if (!empty) begin
          tail = link_mem[tail];
        end
      end
    endcase
    r.ring_empty   = empty;
    r.current_task = empty ? rrtr_pkg::task_t'(0) : tail;
    return r;
  endfunction

  always @(posedge clk) begin
    rrtr_pkg::rsp_t got;
    rrtr_pkg::rsp_t want;
    if (rst) begin
      tail  = '0;
      empty = 1'b1;
      expected_rsp.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = rrtr_pkg::rsp_t'(m_axis_tdata);
        checked_cnt++;
        if (got.not_found) begin
          miss_cnt++;
        end
        if (expected_rsp.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result beat with nothing expected: task %0d empty %0b miss %0b",
                     $time, got.current_task, got.ring_empty, got.not_found);
          end
        end else begin
          want = expected_rsp.pop_front();
          if (got.current_task != want.current_task || got.ring_empty != want.ring_empty ||
              got.not_found != want.not_found) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch: task %0d/%0d empty %0b/%0b miss %0b/%0b (exp/act)",
                       $time, want.current_task, got.current_task, want.ring_empty,
                       got.ring_empty, want.not_found, got.not_found);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsp.push_back(ring_apply(rrtr_pkg::op_t'(s_axis_tdata[1:0]),
                                          rrtr_pkg::task_t'(s_axis_tdata[7:2])));
      end
    end
    pending <= expected_rsp.size();
    errors  <= mismatch_cnt;
    checked <= checked_cnt;
    misses  <= miss_cnt;
  end

endmodule

[tb/tb_top.sv]
module tb_top;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       calm = 1'b0;
  int         pending;
  int         errors;
  int         checked;
  int         misses;
  int         op_count [4];

  round_robin_task_ring dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  rrtr_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .pending       (pending),
    .errors        (errors),
    .checked       (checked),
    .misses        (misses)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 37);
  end

  task automatic send_beat(rrtr_pkg::op_t op, rrtr_pkg::task_t id);
    while (!calm && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {id, op};
    op_count[op]++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_ring;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rrtr_pkg::task_t known [$];
    rrtr_pkg::op_t   op;
    rrtr_pkg::task_t id;
    int              n;
    int              k;
    int              roll;
    logic            filling;
    for (n = 0; n < 4; n++) begin
      op_count[n] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(rrtr_pkg::OP_ADVANCE, 6'd63);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd5);
    send_beat(rrtr_pkg::OP_CLEAR, 6'd0);
    send_beat(rrtr_pkg::OP_ADD, 6'd0);
    send_beat(rrtr_pkg::OP_ADD, 6'd63);
    send_beat(rrtr_pkg::OP_ADD, 6'd21);
    send_beat(rrtr_pkg::OP_ADD, 6'd42);
    send_beat(rrtr_pkg::OP_ADVANCE, 6'd0);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd21);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd0);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd7);
    send_beat(rrtr_pkg::OP_ADD, 6'd63);
    send_beat(rrtr_pkg::OP_ADVANCE, 6'd0);
    send_beat(rrtr_pkg::OP_ADVANCE, 6'd0);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd63);
    send_beat(rrtr_pkg::OP_CLEAR, 6'd63);
    send_beat(rrtr_pkg::OP_ADD, 6'd9);
    send_beat(rrtr_pkg::OP_ADD, 6'd9);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd9);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd9);
    send_beat(rrtr_pkg::OP_ADVANCE, 6'd42);
    send_beat(rrtr_pkg::OP_ADD, 6'd42);
    send_beat(rrtr_pkg::OP_REMOVE, 6'd42);
    drain_ring();

    for (n = 0; n < 600; n++) begin
      calm = (n >= 100 && n < 200);
      filling = (n >= 300 && n < 400);
      if (n == 250) begin
        drain_ring();
      end
      roll = $urandom_range(99);
      if (roll < (filling ? 0 : 3)) begin
        op = rrtr_pkg::OP_CLEAR;
        id = rrtr_pkg::task_t'($urandom_range(63));
        known.delete();
      end else if (roll < (filling ? 65 : 45)) begin
        op = rrtr_pkg::OP_ADD;
        if (known.size() != 0 && $urandom_range(9) == 0) begin
          id = known[$urandom_range(known.size() - 1)];
        end else begin
          id = rrtr_pkg::task_t'($urandom_range(63));
          known.push_back(id);
        end
      end else if (roll < (filling ? 85 : 75)) begin
        op = rrtr_pkg::OP_REMOVE;
        if (known.size() != 0 && $urandom_range(3) != 0) begin
          k  = $urandom_range(known.size() - 1);
          id = known[k];
          known.delete(k);
        end else begin
          id = rrtr_pkg::task_t'($urandom_range(63));
        end
      end else begin
        op = rrtr_pkg::OP_ADVANCE;
        id = rrtr_pkg::task_t'($urandom_range(63));
      end
      send_beat(op, id);
    end
    calm = 1'b0;
    drain_ring();
    repeat (100) @(posedge clk);

    $display("Sent %0d clears, %0d adds, %0d removes and %0d advances.",
             op_count[rrtr_pkg::OP_CLEAR], op_count[rrtr_pkg::OP_ADD],
             op_count[rrtr_pkg::OP_REMOVE], op_count[rrtr_pkg::OP_ADVANCE]);
    $display("Checked %0d result beats, %0d of them removes that missed their task.",
             checked, misses);
    if (errors == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
